>>> rtl/core/bcf_pkg.sv
// package for the bytecode constant folding window
// holds opcode constants, payload structs and the window entry type; no dependencies

package bcf_pkg;

    localparam logic [7:0] OP_CONST_I64  = 8'd1;
    localparam logic [7:0] OP_CONST_BOOL = 8'd2;
    localparam logic [7:0] OP_ADD_I64    = 8'd3;
    localparam logic [7:0] OP_LESS_I64   = 8'd4;
    localparam logic [7:0] OP_ABS_I64    = 8'd5;
    localparam logic [7:0] OP_NIL        = 8'd6;
    localparam logic [7:0] OP_IS_NIL     = 8'd7;

    localparam logic signed [63:0] MIN_I64 = {1'b1, 63'd0};

    localparam int WIN_DEPTH = 3;

    typedef struct packed {
        logic [7:0]         opcode;
        logic signed [63:0] operand;
        logic               is_protected;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_opcode;
        logic signed [63:0] out_operand;
        logic [15:0]        source_index;
        logic               was_folded;
        logic [15:0]        fold_total;
        logic               last_out;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         opcode;
        logic signed [63:0] operand;
        logic               prot;
    } win_entry_t;

    // outcome of deciding the head of the window
    typedef struct packed {
        logic [7:0]         res_opcode;
        logic signed [63:0] res_operand;
        logic [1:0]         used;
        logic               folded;
    } fold_res_t;

endpackage

>>> rtl/core/bcf_decide.sv
// head decision logic: matches the fold patterns over the three-entry window
// depends on bcf_pkg

module bcf_decide (
    input  bcf_pkg::win_entry_t [2:0] win,
    input  logic [1:0]                fill,
    output bcf_pkg::fold_res_t        res
);
    import bcf_pkg::*;

    logic               tri_ok;
    logic               two_ok;
    logic signed [63:0] sum;
    logic               less;
    logic signed [63:0] absval;

    assign tri_ok = (fill == 2'd3) && (win[0].opcode == OP_CONST_I64)
                    && (win[1].opcode == OP_CONST_I64) && !win[1].prot && !win[2].prot;
    assign two_ok = (fill >= 2'd2) && !win[1].prot;

    assign sum    = win[0].operand + win[1].operand;
    assign less   = $signed(win[0].operand) < $signed(win[1].operand);
    assign absval = win[0].operand[63] ? -win[0].operand : win[0].operand;

    always_comb begin
        res.res_opcode  = win[0].opcode;
        res.res_operand = win[0].operand;
        res.used        = 2'd1;
        res.folded      = 1'b0;
        if (tri_ok && win[2].opcode == OP_ADD_I64) begin
            res.res_opcode  = OP_CONST_I64;
            res.res_operand = sum;
            res.used        = 2'd3;
            res.folded      = 1'b1;
        end else if (tri_ok && win[2].opcode == OP_LESS_I64) begin
            res.res_opcode  = OP_CONST_BOOL;
            res.res_operand = {63'd0, less};
            res.used        = 2'd3;
            res.folded      = 1'b1;
        end else if (two_ok && win[0].opcode == OP_CONST_I64 && win[1].opcode == OP_ABS_I64
                     && win[0].operand != MIN_I64) begin
            res.res_opcode  = OP_CONST_I64;
            res.res_operand = absval;
            res.used        = 2'd2;
            res.folded      = 1'b1;
        end else if (two_ok && win[0].opcode == OP_NIL && win[1].opcode == OP_IS_NIL) begin
            res.res_opcode  = OP_CONST_BOOL;
            res.res_operand = 64'sd1;
            res.used        = 2'd2;
            res.folded      = 1'b1;
        end
    end

endmodule

>>> rtl/core/bytecode_constant_fold_window.sv
// channel | dir | handshake         | payload
// s_      | in  | s_valid / s_ready | bcf_pkg::in_item_t, one instruction per transaction
// m_      | out | m_valid / m_ready | bcf_pkg::out_item_t, one surviving or folded instruction
//
// one instruction per cycle sustained while results are taken and no drain runs: the window register feeds one decision
// (one 64-bit adder, one comparator, one negate) straight into the result register.
// the final instruction of a function drains the window: up to three results,
// one per cycle while m_ready allows, during which s_ready is low.
// aresetn is synchronous, active low; it empties the window and clears the counters.
// a stalled result holds the window once it is full; with room left and no drain, input is still taken.
// depends on bcf_pkg and bcf_decide

module bytecode_constant_fold_window #(
    parameter int MAX_CODE = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bcf_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output bcf_pkg::out_item_t m_item
);
    import bcf_pkg::*;

    localparam int PW = $clog2(MAX_CODE);

    win_entry_t [2:0] win_reg, win_next;
    logic [PW-1:0]    win_pos_reg [WIN_DEPTH];
    logic [PW-1:0]    win_pos_next [WIN_DEPTH];
    logic [1:0]       fill_reg, fill_next;
    logic             drain_reg, drain_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [15:0]      fold_cnt_reg, fold_cnt_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    fold_res_t        res;
    logic             out_free;
    logic             can_decide;
    logic             dec_fire;
    logic             last_dec;
    logic             s_fire;
    logic [1:0]       fill_mid;
    logic [1:0]       shift;
    logic [2:0]       src;
    logic [1:0]       src_idx;
    logic [1:0]       last_idx;
    logic [15:0]      fold_total;

    bcf_decide u_decide (
        .win  (win_reg),
        .fill (fill_reg),
        .res  (res)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign can_decide = (fill_reg == 2'd3) || (drain_reg && fill_reg != 2'd0);
    assign dec_fire   = can_decide && out_free;
    assign last_dec   = drain_reg && (res.used == fill_reg);
    assign s_ready    = !drain_reg && ((fill_reg != 2'd3) || dec_fire);
    assign s_fire     = s_valid && s_ready;
    assign shift      = dec_fire ? res.used : 2'd0;
    assign fill_mid   = fill_reg - shift;
    assign last_idx   = res.used - 2'd1;
    assign fold_total = fold_cnt_reg + {15'd0, res.folded};

    always_comb begin
        src          = 3'd0;
        src_idx      = 2'd0;
        win_next     = win_reg;
        win_pos_next = win_pos_reg;
        fill_next    = fill_mid;
        drain_next   = drain_reg;
        pos_next     = pos_reg;
        fold_cnt_next = fold_cnt_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        // drop the decided entries from the front of the window
        for (int i = 0; i < WIN_DEPTH; i++) begin
            src     = 3'(i) + {1'b0, shift};
            src_idx = src[1:0];
            if (src < 3'(WIN_DEPTH)) begin
                win_next[i]     = win_reg[src_idx];
                win_pos_next[i] = win_pos_reg[src_idx];
            end
        end

        if (dec_fire) begin
            m_valid_next             = 1'b1;
            m_item_next.out_opcode   = res.res_opcode;
            m_item_next.out_operand  = res.res_operand;
            m_item_next.source_index = 16'(win_pos_reg[last_idx]);
            m_item_next.was_folded   = res.folded;
            m_item_next.fold_total   = fold_total;
            m_item_next.last_out     = last_dec;
            fold_cnt_next            = fold_total;
            if (last_dec) begin
                fill_next     = 2'd0;
                drain_next    = 1'b0;
                fold_cnt_next = 16'd0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            win_next[fill_mid].opcode  = s_item.opcode;
            win_next[fill_mid].operand = s_item.operand;
            win_next[fill_mid].prot    = s_item.is_protected;
            win_pos_next[fill_mid]     = pos_reg;
            fill_next                  = fill_mid + 2'd1;
            if (s_item.last_in) begin
                drain_next = 1'b1;
                pos_next   = '0;
            end else if (pos_reg == PW'(MAX_CODE - 1)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg     <= win_next;
        win_pos_reg <= win_pos_next;
        m_item_reg  <= m_item_next;
        if (!aresetn) begin
            fill_reg     <= 2'd0;
            drain_reg    <= 1'b0;
            pos_reg      <= '0;
            fold_cnt_reg <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            drain_reg    <= drain_next;
            pos_reg      <= pos_next;
            fold_cnt_reg <= fold_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    a_no_accept_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> !s_ready)
        else $error("instruction taken while the window drains");

    a_empty_not_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd0) |-> !drain_reg)
        else $error("drain flag set with an empty window");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_fire && last_dec) |=> (fill_reg == 2'd0 && !drain_reg && fold_cnt_reg == 16'd0))
        else $error("function end did not clear the window state");

    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_item.last_in) |=> (drain_reg && pos_reg == '0))
        else $error("final instruction did not start the drain");
`endif

endmodule

>>> test/testbench.sv
// self-checking testbench for bytecode_constant_fold_window: directed fold cases, then random traffic
// predicts each folded or surviving instruction in step with the accepted input stream
// depends on bcf_pkg and the rtl of the folding window
`timescale 1ns / 1ps

module testbench;
    import bcf_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] MAX_I64     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG_I64     = 64'h8000_0000_0000_0000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // predictor state
    win_entry_t  fold_win [3];
    int unsigned win_fill   = 0;
    logic [15:0] pos_count  = '0;
    logic [15:0] fold_count = '0;
    out_item_t   fold_expect [$];

    int        send_idle_pct = 27;
    int        recv_idle_pct = 76;
    int        items_sent    = 0;
    int        results_seen  = 0;
    int        error_count   = 0;
    int        cycle_count   = 0;
    out_item_t next_result;

    bytecode_constant_fold_window dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // decide the head of the window, emitting one expected result
    task automatic fold_head(input bit at_end);
        int unsigned n;
        int unsigned used;
        int          i;
        logic [7:0]  res_op;
        logic [63:0] res_val;
        logic [15:0] base;
        out_item_t   r;
        n       = win_fill;
        res_op  = fold_win[0].opcode;
        res_val = fold_win[0].operand;
        used    = 1;
        base    = pos_count - 16'(n);
        if (n >= 3 && fold_win[0].opcode == OP_CONST_I64 && fold_win[1].opcode == OP_CONST_I64
                && !fold_win[1].prot && !fold_win[2].prot) begin
            if (fold_win[2].opcode == OP_ADD_I64) begin
                res_op  = OP_CONST_I64;
                res_val = fold_win[0].operand + fold_win[1].operand;
                used    = 3;
            end else if (fold_win[2].opcode == OP_LESS_I64) begin
                res_op  = OP_CONST_BOOL;
                res_val = ($signed(fold_win[0].operand) < $signed(fold_win[1].operand))
                          ? 64'd1 : 64'd0;
                used    = 3;
            end
        end
        if (used == 1 && n >= 2 && fold_win[0].opcode == OP_CONST_I64
                && fold_win[1].opcode == OP_ABS_I64 && !fold_win[1].prot
                && fold_win[0].operand != NEG_I64) begin
            res_op  = OP_CONST_I64;
            res_val = fold_win[0].operand[63] ? 64'd0 - fold_win[0].operand : fold_win[0].operand;
            used    = 2;
        end
        if (used == 1 && n >= 2 && fold_win[0].opcode == OP_NIL
                && fold_win[1].opcode == OP_IS_NIL && !fold_win[1].prot) begin
            res_op  = OP_CONST_BOOL;
            res_val = 64'd1;
            used    = 2;
        end
        if (used > 1)
            fold_count = fold_count + 16'd1;
        r.out_opcode   = res_op;
        r.out_operand  = res_val;
        r.source_index = base + 16'(used) - 16'd1;
        r.was_folded   = (used > 1);
        r.fold_total   = fold_count;
        r.last_out     = at_end && (used == n);
        fold_expect.insert(fold_expect.size(), r);
        for (i = 0; i + used < 3; i++)
            fold_win[i] = fold_win[i + used];
        win_fill = n - used;
    endtask

    task automatic predict_instr(input in_item_t it);
        int count;
        count = 0;
        fold_win[win_fill] = '{opcode: it.opcode, operand: it.operand, prot: it.is_protected};
        win_fill++;
        pos_count = pos_count + 16'd1;
        if (it.last_in) begin
            // end of function: drain everything and restart the counters
            while (win_fill > 0 && count < 3) begin
                fold_head(1'b1);
                count++;
            end
            win_fill   = 0;
            pos_count  = '0;
            fold_count = '0;
        end else if (win_fill == 3) begin
            fold_head(1'b0);
        end
    endtask

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_instr(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_instr(it);
        items_sent++;
    endtask

    // always lets at least one edge pass with valid low
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (fold_expect.size() != 0)
            @(posedge aclk);
    endtask

    function automatic in_item_t mk(input logic [7:0] op, input logic [63:0] val,
                                    input bit prot, input bit last);
        in_item_t it;
        it.opcode       = op;
        it.operand      = val;
        it.is_protected = prot;
        it.last_in      = last;
        return it;
    endfunction

    function automatic in_item_t rand_instr(input logic [7:0] op, input logic [63:0] val);
        return mk(op, val, $urandom_range(9) == 0, $urandom_range(13) == 0);
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(9))
            0: return NEG_I64;
            1: return MAX_I64;
            2: return '1;
            3: return '0;
            4, 5: return 64'($urandom_range(200)) - 64'd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_add_fold();
        send_instr(mk(OP_CONST_I64, MAX_I64, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_I64, 64'd1, 1'b0, 1'b0));
        send_instr(mk(OP_ADD_I64, 64'd0, 1'b0, 1'b0));
    endtask

    task automatic test_less_fold();
        send_instr(mk(OP_CONST_I64, NEG_I64, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_I64, MAX_I64, 1'b0, 1'b0));
        send_instr(mk(OP_LESS_I64, 64'd0, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_I64, MAX_I64, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_I64, NEG_I64, 1'b0, 1'b0));
        send_instr(mk(OP_LESS_I64, 64'd0, 1'b0, 1'b1));
    endtask

    task automatic test_abs_fold();
        // the minimum has no absolute value and must pass unfolded
        send_instr(mk(OP_CONST_I64, NEG_I64, 1'b0, 1'b0));
        send_instr(mk(OP_ABS_I64, 64'd0, 1'b0, 1'b1));
        // protection of the head itself does not block a fold
        send_instr(mk(OP_CONST_I64, -64'sd5, 1'b1, 1'b0));
        send_instr(mk(OP_ABS_I64, 64'd0, 1'b0, 1'b0));
    endtask

    task automatic test_nil_fold();
        send_instr(mk(OP_NIL, 64'd0, 1'b0, 1'b0));
        send_instr(mk(OP_IS_NIL, 64'd0, 1'b0, 1'b1));
    endtask

    task automatic test_protected_followers();
        send_instr(mk(OP_CONST_I64, 64'd1, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_I64, 64'd2, 1'b1, 1'b0));
        send_instr(mk(OP_ADD_I64, 64'd0, 1'b0, 1'b0));
        send_instr(mk(OP_NIL, 64'd0, 1'b0, 1'b0));
        send_instr(mk(OP_IS_NIL, 64'd0, 1'b1, 1'b1));
    endtask

    task automatic test_function_ends();
        send_instr(mk(8'hff, '1, 1'b1, 1'b1));
        send_instr(mk(8'h00, '0, 1'b0, 1'b0));
        send_instr(mk(OP_CONST_BOOL, 64'd1, 1'b0, 1'b0));
        send_instr(mk(8'h80, {$urandom, $urandom}, 1'b0, 1'b1));
    endtask

    // mostly foldable sequences with random content, the rest near misses and noise
    task automatic send_random_pattern();
        logic [63:0] v;
        case ($urandom_range(9))
            0, 1: begin
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(OP_ADD_I64, rand_operand()));
            end
            2, 3: begin
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(OP_LESS_I64, rand_operand()));
            end
            4: begin
                v = ($urandom_range(3) == 0) ? NEG_I64 : rand_operand();
                send_instr(rand_instr(OP_CONST_I64, v));
                send_instr(rand_instr(OP_ABS_I64, rand_operand()));
            end
            5: begin
                send_instr(rand_instr(OP_NIL, rand_operand()));
                send_instr(rand_instr(OP_IS_NIL, rand_operand()));
            end
            6: begin
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(OP_CONST_I64, rand_operand()));
                send_instr(rand_instr(8'($urandom_range(8)), rand_operand()));
            end
            default: begin
                v = $urandom_range(1) ? 64'($urandom_range(255)) : 64'($urandom_range(8));
                send_instr(rand_instr(v[7:0], rand_operand()));
            end
        endcase
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int target;
        target        = items_sent + n_items;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent < target)
            send_random_pattern();
        hold_until_drained();
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fold_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected result opcode %0h source %0d",
                                          m_item.out_opcode, m_item.source_index));
            end else begin
                next_result = fold_expect[0];
                fold_expect.delete(0);
                check_field("opcode", m_item.out_opcode, next_result.out_opcode);
                check_field("operand", m_item.out_operand, next_result.out_operand);
                check_field("source_index", m_item.source_index, next_result.source_index);
                check_field("was_folded", m_item.was_folded, next_result.was_folded);
                check_field("fold_total", m_item.fold_total, next_result.fold_total);
                check_field("last_out", m_item.last_out, next_result.last_out);
            end
            results_seen++;
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_add_fold();
        test_less_fold();
        test_abs_fold();
        test_nil_fold();
        test_protected_followers();
        test_function_ends();
        test_random_traffic(27, 76, 145);
        test_random_traffic(76, 27, 145);
        test_random_traffic(0, 0, 145);
        // close the last function so the window is flushed
        send_instr(mk(OP_NIL, 64'd0, 1'b0, 1'b1));
        hold_until_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
